>>> design/spld_pkg.sv
// shared constants and codes for the spectrum peak led driver
`timescale 1ns / 1ps
`default_nettype none

package spld_pkg;

   // data path widths
   localparam int unsigned RADICAND_W = 32;
   localparam int unsigned ROOT_W     = 16;
   localparam int unsigned MAG_W      = 15;
   localparam int unsigned PROD_W     = 26;
   localparam int unsigned QUOT_W     = 16;
   localparam int unsigned DUTY_W     = 10;

   // square root iterations, two radicand bits each
   localparam int unsigned ROOT_STEPS = RADICAND_W / 2;

   // constant divider for compare scaling
   localparam int unsigned DIVISOR    = 1000;
   localparam int unsigned DIV_REM_W  = 10;

   localparam logic [MAG_W-1:0] MAG_MAX = 15'd32767;

   // configuration register indexes
   localparam logic CSR_MODE   = 1'b0;
   localparam logic CSR_PERIOD = 1'b1;

   // display programs
   localparam logic [1:0] MODE_BAND = 2'd0;
   localparam logic [1:0] MODE_PEAK = 2'd1;
   localparam logic [1:0] MODE_FREQ = 2'd2;

   localparam logic [15:0] PWM_PERIOD_RESET = 16'd999;

   // led port patterns
   localparam logic [6:0] LED_OFF = 7'h00;
   localparam logic [6:0] LED1    = 7'h10;
   localparam logic [6:0] LED2    = 7'h20;
   localparam logic [6:0] LED3    = 7'h40;
   localparam logic [6:0] LED4    = 7'h02;

   // magnitude thresholds
   localparam logic [MAG_W-1:0] PEAK_BAND_LED1 = 15'd1000;
   localparam logic [MAG_W-1:0] PEAK_LEVEL_3   = 15'd600;
   localparam logic [MAG_W-1:0] PEAK_LEVEL_2   = 15'd1200;
   localparam logic [MAG_W-1:0] PEAK_LEVEL_1   = 15'd5000;
   localparam logic [MAG_W-1:0] BAND_FULL      = 15'd600;

   localparam logic [DUTY_W-1:0] DUTY_FULL = 10'd1000;

   // floor(5*m/3) == (m * 218455) >> 17 for m below 600
   localparam logic [17:0] FIVE_THIRDS_MUL   = 18'd218455;
   localparam int unsigned FIVE_THIRDS_SHIFT = 17;

endpackage

`default_nettype wire

>>> design/spld_isqrt.sv
// digit-by-digit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module spld_isqrt (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [spld_pkg::RADICAND_W-1:0]  radicand,
   output logic                                  done,
   output logic      [spld_pkg::ROOT_W-1:0]      root
);

   localparam int unsigned CNT_W = $clog2(spld_pkg::ROOT_STEPS);
   localparam int unsigned REM_W = spld_pkg::ROOT_W + 1;
   localparam int unsigned TRY_W = REM_W + 2;

   logic                              busy_ff,  busy_in;
   logic                              done_ff,  done_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [spld_pkg::RADICAND_W-1:0]   rad_ff,   rad_in;
   logic [REM_W-1:0]                  rem_ff,   rem_in;
   logic [spld_pkg::ROOT_W-1:0]       root_ff,  root_in;

   logic [TRY_W-1:0] shifted_rem;
   logic [TRY_W-1:0] trial;
   logic [TRY_W-1:0] diff;

   always_comb begin
      shifted_rem = {rem_ff, rad_ff[spld_pkg::RADICAND_W-1 -: 2]};
      trial       = {1'b0, root_ff, 2'b01};
      diff        = shifted_rem - trial;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;

      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[spld_pkg::RADICAND_W-3:0], 2'b00};
         if (shifted_rem >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[spld_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted_rem[REM_W-1:0];
            root_in = {root_ff[spld_pkg::ROOT_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(spld_pkg::ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

>>> design/spld_div1000.sv
// bit-serial restoring division by the constant compare scale
`timescale 1ns / 1ps
`default_nettype none

module spld_div1000 (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [spld_pkg::PROD_W-1:0]   dividend,
   output logic                               done,
   output logic      [spld_pkg::QUOT_W-1:0]   quotient
);

   localparam int unsigned CNT_W = $clog2(spld_pkg::PROD_W);
   localparam int unsigned TRY_W = spld_pkg::DIV_REM_W + 1;
   localparam logic [TRY_W-1:0] DIVISOR_T = TRY_W'(spld_pkg::DIVISOR);

   logic                            busy_ff,  busy_in;
   logic                            done_ff,  done_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [spld_pkg::PROD_W-1:0]     num_ff,   num_in;
   logic [spld_pkg::DIV_REM_W-1:0]  rem_ff,   rem_in;
   logic [spld_pkg::QUOT_W-1:0]     quot_ff,  quot_in;

   logic [TRY_W-1:0] shifted_rem;
   logic [TRY_W-1:0] diff;

   always_comb begin
      shifted_rem = {rem_ff, num_ff[spld_pkg::PROD_W-1]};
      diff        = shifted_rem - DIVISOR_T;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;

      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = dividend;
         rem_in   = '0;
         quot_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[spld_pkg::PROD_W-2:0], 1'b0};
         if (shifted_rem >= DIVISOR_T) begin
            rem_in  = diff[spld_pkg::DIV_REM_W-1:0];
            quot_in = {quot_ff[spld_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted_rem[spld_pkg::DIV_REM_W-1:0];
            quot_in = {quot_ff[spld_pkg::QUOT_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(spld_pkg::PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

>>> design/spectrum_peak_led_driver_core.sv
// top level: per-bin magnitude, frame peak tracking and led pattern result
//
// req channel carries one complex spectrum bin per transfer; req_tlast marks
// the final bin of a frame. a bin holds the core from its transfer to the
// earliest next transfer: squaring of the real and the imaginary part, the
// root start, a 16-step digit-serial square root (two radicand bits per cycle),
// folding the magnitude into the peak, low band and mid band trackers, and
// the idle state that takes the next bin.
// after the last bin come duty scaling, product, divider start, then two
// bit-serial dividers by 1000 that run side by side for 26 steps, then the
// result load into the rsp output register, which waits until that register
// is free.
// one rsp transfer per frame, none for other bins. the result sits in the
// output register, so the next frame's bins are taken while it waits; only
// a second frame end stalls (req_tready low) until rsp_tready drains it.
// csr writes (index 0 mode, index 1 pwm period) are taken every cycle and
// belong in idle periods. reset: mode 0, period 999, frame trackers cleared,
// no result pending. frame state clears again after every result.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_peak_led_driver_core #(
   parameter int unsigned BINS = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // bin input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // re_part[15:0], im_part[31:16]
   input  wire logic        req_tlast,  // last_bin

   // frame result
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // led_port[6:0], low_compare[22:7], mid_compare[38:23],
   // peak_value[53:39], peak_bin[62:54], zero[63]
   output logic      [63:0] rsp_tdata,
   output logic             rsp_tuser,  // update_pwm

   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned IDX_W = $clog2(BINS);
   localparam int unsigned MAG_W = spld_pkg::MAG_W;

   // band edges, inclusive
   localparam logic [IDX_W:0] LOW_LO = (IDX_W+1)'(20 * BINS / 8000);
   localparam logic [IDX_W:0] LOW_HI = (IDX_W+1)'(700 * BINS / 8000);
   localparam logic [IDX_W:0] MID_LO = (IDX_W+1)'(700 * BINS / 8000);
   localparam logic [IDX_W:0] MID_HI = (IDX_W+1)'(7000 * BINS / 8000);
   localparam logic [IDX_W:0] BIN_END = (IDX_W+1)'(BINS);

   // bin*8000 < f*BINS  <=>  bin < ceil(f*BINS/8000)
   localparam logic [IDX_W:0] FREQ_LOW_LIMIT = (IDX_W+1)'((200 * BINS + 7999) / 8000);
   localparam logic [IDX_W:0] FREQ_MID_LIMIT = (IDX_W+1)'((2000 * BINS + 7999) / 8000);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_ROOT_GO,
      ST_ROOT,
      ST_DUTY,
      ST_SCALE,
      ST_DIV_GO,
      ST_DIV,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [1:0]  mode_ff,   mode_in;
   logic [15:0] period_ff, period_in;

   // current bin
   logic [16:0] abs_re_ff, abs_re_in;
   logic [16:0] abs_im_ff, abs_im_in;
   logic        last_ff,   last_in;
   logic [30:0] sq_re_ff,  sq_re_in;
   logic [30:0] sq_im_ff,  sq_im_in;

   // frame trackers
   logic [IDX_W-1:0] bin_count_ff,  bin_count_in;
   logic [MAG_W-1:0] peak_mag_ff,   peak_mag_in;
   logic [IDX_W-1:0] peak_index_ff, peak_index_in;
   logic [MAG_W-1:0] low_max_ff,    low_max_in;
   logic [MAG_W-1:0] mid_max_ff,    mid_max_in;

   // frame end scaling
   logic [spld_pkg::DUTY_W-1:0] duty_low_ff, duty_low_in;
   logic [spld_pkg::DUTY_W-1:0] duty_mid_ff, duty_mid_in;
   logic [spld_pkg::PROD_W-1:0] prod_low_ff, prod_low_in;
   logic [spld_pkg::PROD_W-1:0] prod_mid_ff, prod_mid_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff,  rsp_data_in;
   logic        rsp_user_ff,  rsp_user_in;

   // unit hookups
   logic                              root_start;
   logic [spld_pkg::RADICAND_W-1:0]   radicand;
   logic                              root_done;
   logic [spld_pkg::ROOT_W-1:0]       root;
   logic                              div_start;
   logic                              div_low_done, div_mid_done;
   logic [spld_pkg::QUOT_W-1:0]       quot_low, quot_mid;

   // helpers
   logic [16:0]      re_ext, im_ext;
   logic [33:0]      re_square, im_square;
   logic [MAG_W-1:0] mag;
   logic [IDX_W:0]   idx_ext, idx_next;
   logic [IDX_W:0]   peak_idx_ext;
   logic [27:0]      five_low, five_mid;
   logic [IDX_W+8:0] peak_bin_wide;
   logic [6:0]       led;
   logic             upd;
   logic [15:0]      low_cmp, mid_cmp;

   spld_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   spld_div1000 u_div_low (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_low_ff),
      .done     (div_low_done),
      .quotient (quot_low)
   );

   spld_div1000 u_div_mid (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mid_ff),
      .done     (div_mid_done),
      .quotient (quot_mid)
   );

   always_comb begin
      // magnitude of a two's complement part, 17 bits so -32768 fits
      re_ext    = {req_tdata[15], req_tdata[15:0]};
      im_ext    = {req_tdata[31], req_tdata[31:16]};
      re_square = abs_re_ff * abs_re_ff;
      im_square = abs_im_ff * abs_im_ff;
      radicand  = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};

      // saturate roots above 32767
      mag      = root[spld_pkg::ROOT_W-1] ? spld_pkg::MAG_MAX : root[MAG_W-1:0];
      idx_ext  = {1'b0, bin_count_ff};
      idx_next = idx_ext + 1'b1;

      five_low = 28'(low_max_ff[spld_pkg::DUTY_W-1:0]) * 28'(spld_pkg::FIVE_THIRDS_MUL);
      five_mid = 28'(mid_max_ff[spld_pkg::DUTY_W-1:0]) * 28'(spld_pkg::FIVE_THIRDS_MUL);

      peak_idx_ext  = {1'b0, peak_index_ff};
      peak_bin_wide = {9'd0, peak_index_ff};

      // led pattern by display program
      led     = spld_pkg::LED_OFF;
      upd     = 1'b0;
      low_cmp = '0;
      mid_cmp = '0;
      case (mode_ff)
         spld_pkg::MODE_BAND: begin
            led     = (peak_mag_ff > spld_pkg::PEAK_BAND_LED1) ? spld_pkg::LED1
                                                               : spld_pkg::LED4;
            upd     = 1'b1;
            low_cmp = quot_low;
            mid_cmp = quot_mid;
         end
         spld_pkg::MODE_PEAK: begin
            if (peak_mag_ff <= spld_pkg::PEAK_LEVEL_3) begin
               led = spld_pkg::LED3;
            end else if (peak_mag_ff <= spld_pkg::PEAK_LEVEL_2) begin
               led = spld_pkg::LED2;
            end else if (peak_mag_ff <= spld_pkg::PEAK_LEVEL_1) begin
               led = spld_pkg::LED1;
            end else begin
               led = spld_pkg::LED_OFF;
            end
         end
         spld_pkg::MODE_FREQ: begin
            if (peak_idx_ext < FREQ_LOW_LIMIT) begin
               led = spld_pkg::LED3;
            end else if (peak_idx_ext < FREQ_MID_LIMIT) begin
               led = spld_pkg::LED2;
            end else begin
               led = spld_pkg::LED1;
            end
         end
         default: begin
            led = spld_pkg::LED_OFF;
         end
      endcase

      state_in      = state_ff;
      mode_in       = mode_ff;
      period_in     = period_ff;
      abs_re_in     = abs_re_ff;
      abs_im_in     = abs_im_ff;
      last_in       = last_ff;
      sq_re_in      = sq_re_ff;
      sq_im_in      = sq_im_ff;
      bin_count_in  = bin_count_ff;
      peak_mag_in   = peak_mag_ff;
      peak_index_in = peak_index_ff;
      low_max_in    = low_max_ff;
      mid_max_in    = mid_max_ff;
      duty_low_in   = duty_low_ff;
      duty_mid_in   = duty_mid_ff;
      prod_low_in   = prod_low_ff;
      prod_mid_in   = prod_mid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      root_start    = 1'b0;
      div_start     = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            spld_pkg::CSR_MODE:   mode_in   = csr_data[1:0];
            spld_pkg::CSR_PERIOD: period_in = csr_data;
            default: ;
         endcase
      end

      // result transfer drains the output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               abs_re_in = re_ext[16] ? (17'd0 - re_ext) : re_ext;
               abs_im_in = im_ext[16] ? (17'd0 - im_ext) : im_ext;
               last_in   = req_tlast;
               state_in  = ST_SQ_RE;
            end
         end
         ST_SQ_RE: begin
            sq_re_in = re_square[30:0];
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            sq_im_in = im_square[30:0];
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               // earliest bin keeps an equal peak
               if (mag > peak_mag_ff) begin
                  peak_mag_in   = mag;
                  peak_index_in = bin_count_ff;
               end
               if (idx_ext >= LOW_LO && idx_ext <= LOW_HI && mag > low_max_ff) begin
                  low_max_in = mag;
               end
               if (idx_ext >= MID_LO && idx_ext <= MID_HI && mag > mid_max_ff) begin
                  mid_max_in = mag;
               end
               // index wraps on frames longer than BINS
               bin_count_in = (idx_next >= BIN_END) ? '0 : idx_next[IDX_W-1:0];
               state_in     = last_ff ? ST_DUTY : ST_IDLE;
            end
         end
         ST_DUTY: begin
            duty_low_in = (low_max_ff >= spld_pkg::BAND_FULL) ? spld_pkg::DUTY_FULL
               : five_low[spld_pkg::FIVE_THIRDS_SHIFT +: spld_pkg::DUTY_W];
            duty_mid_in = (mid_max_ff >= spld_pkg::BAND_FULL) ? spld_pkg::DUTY_FULL
               : five_mid[spld_pkg::FIVE_THIRDS_SHIFT +: spld_pkg::DUTY_W];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_low_in = spld_pkg::PROD_W'(duty_low_ff) * spld_pkg::PROD_W'(period_ff);
            prod_mid_in = spld_pkg::PROD_W'(duty_mid_ff) * spld_pkg::PROD_W'(period_ff);
            state_in    = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_low_done && div_mid_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {1'b0, peak_bin_wide[8:0], peak_mag_ff, mid_cmp, low_cmp, led};
               rsp_user_in   = upd;
               bin_count_in  = '0;
               peak_mag_in   = '0;
               peak_index_in = '0;
               low_max_in    = '0;
               mid_max_in    = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= spld_pkg::MODE_BAND;
         period_ff     <= spld_pkg::PWM_PERIOD_RESET;
         bin_count_ff  <= '0;
         peak_mag_ff   <= '0;
         peak_index_ff <= '0;
         low_max_ff    <= '0;
         mid_max_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         period_ff     <= period_in;
         bin_count_ff  <= bin_count_in;
         peak_mag_ff   <= peak_mag_in;
         peak_index_ff <= peak_index_in;
         low_max_ff    <= low_max_in;
         mid_max_ff    <= mid_max_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      abs_re_ff   <= abs_re_in;
      abs_im_ff   <= abs_im_in;
      last_ff     <= last_in;
      sq_re_ff    <= sq_re_in;
      sq_im_ff    <= sq_im_in;
      duty_low_ff <= duty_low_in;
      duty_mid_ff <= duty_mid_in;
      prod_low_ff <= prod_low_in;
      prod_mid_ff <= prod_mid_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire
